### sv/self_shrinking_bit_packer_assert.svh
// ---------------------------------------------------------------------------
// self-shrinking bit packer assertion macros
// shared concurrent check forms, clocked on the rising edge, held off in reset
// ---------------------------------------------------------------------------
`ifndef SELF_SHRINKING_BIT_PACKER_ASSERT_SVH
`define SELF_SHRINKING_BIT_PACKER_ASSERT_SVH

// property that must hold at every edge outside reset
`define SSBP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("ssbp check failed");

// overlapping implication outside reset
`define SSBP_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ssbp implication failed");

// next-cycle implication outside reset
`define SSBP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ssbp next-cycle check failed");

`endif

### sv/ssbp_pkg.sv
// ---------------------------------------------------------------------------
// ssbp_pkg
// shared constants, types and the self-shrinking byte rule
// ---------------------------------------------------------------------------
`default_nettype none

package ssbp_pkg;

  localparam int WORD_W    = 64;
  localparam int BYTE_W    = 8;
  localparam int MAX_LANES = WORD_W / BYTE_W;
  // lanes in use, from the low byte up; 1 to MAX_LANES
  localparam int LANES     = 8;
  localparam int CARRY_W   = 7;
  localparam int CCOUNT_W  = 3;
  localparam int KEEP_W    = 4;            // kept bits per byte, at most
  localparam int KCOUNT_W  = 3;            // 0..4
  localparam int MAX_BYTES = 4;
  localparam int NBYTES_W  = 3;            // 0..4
  localparam int BIDX_W    = 2;
  localparam int STREAM_W  = CARRY_W + KEEP_W * MAX_LANES;  // 39
  localparam int POS_W     = 6;            // holds 0..39

  typedef struct packed {
    logic [KEEP_W-1:0]   bits;
    logic [KCOUNT_W-1:0] count;
  } lane_res_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [NBYTES_W-1:0]              nbytes;
  } merge_res_t;

  // four pairs, lowest first; a pair with its upper bit set keeps its lower bit
  function automatic lane_res_t shrink_byte(input logic [BYTE_W-1:0] b);
    lane_res_t r;
    r.bits  = '0;
    r.count = '0;
    for (int p = 0; p < 4; p++) begin
      if (b[2*p+1]) begin
        r.bits[r.count[1:0]] = b[2*p];
        r.count = r.count + 3'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/ssbp_word_if.sv
// ---------------------------------------------------------------------------
// ssbp_word_if
// input channel: one raw 64-bit source word per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface ssbp_word_if
  import ssbp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] source_word;

  modport source (output valid, output source_word, input ready);
  modport sink   (input valid, input source_word, output ready);
endinterface

`default_nettype wire

### sv/ssbp_byte_if.sv
// ---------------------------------------------------------------------------
// ssbp_byte_if
// output channel: one packed byte and its last-of-word mark per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface ssbp_byte_if
  import ssbp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/ssbp_lane.sv
// ---------------------------------------------------------------------------
// ssbp_lane
// one lane: self-shrinking rule on one byte of the source word
// ---------------------------------------------------------------------------
`default_nettype none

module ssbp_lane
  import ssbp_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_in,
  output lane_res_t         res
);

  assign res = shrink_byte(byte_in);

endmodule

`default_nettype wire

### sv/ssbp_merge.sv
// ---------------------------------------------------------------------------
// ssbp_merge
// joins lane results behind the carry bits, cuts whole bytes, keeps the rest
// ---------------------------------------------------------------------------
`default_nettype none

`include "self_shrinking_bit_packer_assert.svh"

module ssbp_merge
  import ssbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_res_t  lanes [LANES],
  input  logic       fire,
  output merge_res_t res
);

  logic [CARRY_W-1:0]  carry_bits;
  logic [CCOUNT_W-1:0] carry_count;
  logic [CARRY_W-1:0]  carry_bits_next;
  logic [POS_W-1:0]    pos [LANES];
  logic [POS_W-1:0]    total;
  logic [STREAM_W-1:0] stream;
  logic [STREAM_W-1:0] rest;

  // bit offset of each lane in the joined stream
  always_comb begin
    pos[0] = POS_W'(carry_count);
    for (int i = 1; i < LANES; i++) begin
      pos[i] = pos[i-1] + POS_W'(lanes[i-1].count);
    end
    total = pos[LANES-1] + POS_W'(lanes[LANES-1].count);
  end

  // lane bits land at independent offsets; bits above each count are zero
  always_comb begin
    stream = STREAM_W'(carry_bits);
    for (int i = 0; i < LANES; i++) begin
      stream = stream | (STREAM_W'(lanes[i].bits) << pos[i]);
    end
  end

  assign rest            = stream >> {total[POS_W-1:3], 3'b000};
  assign carry_bits_next = rest[CARRY_W-1:0];

  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      res.bytes[k] = stream[k*BYTE_W +: BYTE_W];
    end
    res.nbytes = total[POS_W-1:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_bits  <= '0;
      carry_count <= '0;
    end else if (fire) begin
      carry_bits  <= carry_bits_next;
      carry_count <= total[2:0];
    end
  end

  `SSBP_ASSERT(a_carry_clean, clk, rst, (carry_bits >> carry_count) == 7'd0)
  `SSBP_ASSERT_NEXT(a_carry_count, clk, rst, fire, carry_count == $past(total[2:0]))
  `SSBP_ASSERT_NEXT(a_carry_hold, clk, rst, !fire, $stable(carry_bits) && $stable(carry_count))

endmodule

`default_nettype wire

### sv/ssbp_outbuf.sv
// ---------------------------------------------------------------------------
// ssbp_outbuf
// holds the bytes of one word and hands them out one beat at a time
// ---------------------------------------------------------------------------
`default_nettype none

`include "self_shrinking_bit_packer_assert.svh"

module ssbp_outbuf
  import ssbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  merge_res_t         res,
  output logic               free,
  ssbp_byte_if.source        out_ch
);

  logic [MAX_BYTES-1:0][BYTE_W-1:0] obuf;
  logic                             obuf_valid;
  logic [BIDX_W-1:0]                oidx;
  logic [BIDX_W-1:0]                olast;
  logic                             pop;
  logic [NBYTES_W-1:0]              last_idx;

  assign pop      = obuf_valid && out_ch.ready;
  assign free     = !obuf_valid || (pop && (oidx == olast));
  assign last_idx = res.nbytes - NBYTES_W'(1);

  assign out_ch.valid       = obuf_valid;
  assign out_ch.out_byte    = obuf[oidx];
  assign out_ch.last_of_run = (oidx == olast);

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      oidx       <= '0;
      olast      <= '0;
    end else if (load) begin
      obuf_valid <= 1'b1;
      oidx       <= '0;
      olast      <= last_idx[BIDX_W-1:0];
    end else if (pop) begin
      if (oidx == olast) begin
        obuf_valid <= 1'b0;
        oidx       <= '0;
      end else begin
        oidx <= oidx + BIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf <= res.bytes;
    end
  end

  `SSBP_ASSERT_IMPLY(a_empty_idx, clk, rst, !obuf_valid, oidx == 2'd0)
  `SSBP_ASSERT_NEXT(a_step, clk, rst, pop && (oidx != olast),
                    obuf_valid && (oidx == $past(oidx) + 2'd1))
  `SSBP_ASSERT_NEXT(a_after_last, clk, rst, pop && (oidx == olast),
                    !obuf_valid || (oidx == 2'd0))

endmodule

`default_nettype wire

### sv/self_shrinking_bit_packer.sv
// ---------------------------------------------------------------------------
// self_shrinking_bit_packer
// self-shrinking rule over a 64-bit word, kept bits packed into bytes
// ---------------------------------------------------------------------------
// usage:
//   words        : sink channel, one 64-bit source word per beat
//   packed_bytes : source channel, one byte per beat, last_of_run set on the
//                  final byte a word produced; a word may produce no byte
// path: a taken word passes the lane register, then the merge loads the output
//   buffer when it is free, and the buffer then hands over its first byte
// flow: a word yielding bytes waits until the output buffer is free, and the
//   one-byte output channel sets the word rate; words yielding no byte pass
//   without waiting, even while bytes are pending
// stalls: the output buffer holds its bytes while packed_bytes.ready is low;
//   the lane register holds the next word, so a new word is taken at the
//   edge where the buffer hands over its final byte
// reset: synchronous rst empties both stages and clears the carry buffer
// ---------------------------------------------------------------------------
`default_nettype none

module self_shrinking_bit_packer
  import ssbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ssbp_word_if.sink   words,
  ssbp_byte_if.source packed_bytes
);

  lane_res_t  lane_res [LANES];   // lane outputs straight from the input beat
  lane_res_t  s1_lanes [LANES];   // registered lane results
  logic       s1_valid;
  merge_res_t merged;
  logic       buf_free;
  logic       fire;
  logic       load;

  // one lane per byte in use, lowest byte first
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ssbp_lane u_lane (
      .byte_in (words.source_word[i*BYTE_W +: BYTE_W]),
      .res     (lane_res[i])
    );
  end

  // merge fires when its bytes have a place, or when there are none
  assign fire        = s1_valid && (buf_free || (merged.nbytes == NBYTES_W'(0)));
  assign load        = fire && (merged.nbytes != NBYTES_W'(0));
  assign words.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (words.ready) begin
      s1_valid <= words.valid;
    end
  end

  // lane results need no reset, s1_valid guards them
  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      s1_lanes <= lane_res;
    end
  end

  ssbp_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .lanes (s1_lanes),
    .fire  (fire),
    .res   (merged)
  );

  ssbp_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .res    (merged),
    .free   (buf_free),
    .out_ch (packed_bytes)
  );

endmodule

`default_nettype wire

### tb/self_shrinking_bit_packer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// self_shrinking_bit_packer_tb
// drives 64-bit source words into the packer and checks every packed byte
// and its last-of-word mark against a scoreboard. The scoreboard applies the
// self-shrinking rule to each accepted word and keeps its own carry buffer.
// ---------------------------------------------------------------------------

module self_shrinking_bit_packer_tb;
  import ssbp_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int DRAIN_WAIT  = 16;    // settle time after the last byte
  localparam int RANDOM_WORDS = 260;
  localparam int MAX_GAP     = 12;

  // one expected output beat
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // -------------------------------------------------------------------------
  // scoreboard: shrinks each accepted word, queues the bytes it completes
  // -------------------------------------------------------------------------
  class shrink_scoreboard;
    packed_byte_t         pending_bytes[$];
    logic [CARRY_W-1:0]   carry_bits;
    logic [CCOUNT_W-1:0]  carry_count;

    function new();
      carry_bits  = '0;
      carry_count = '0;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    // apply the rule lane by lane, low byte first, low pair first
    function void take_word(input logic [WORD_W-1:0] word);
      logic [15:0]       acc;
      int                fill;
      int                made;
      logic [BYTE_W-1:0] lane_byte;
      packed_byte_t      fresh[MAX_BYTES];
      acc  = 16'(carry_bits);
      fill = int'(carry_count);
      made = 0;
      for (int lane = 0; lane < LANES && lane < MAX_LANES; lane++) begin
        lane_byte = word[BYTE_W*lane +: BYTE_W];
        for (int p = 0; p < 4; p++) begin
          if (lane_byte[2*p+1]) begin
            acc[fill] = lane_byte[2*p];
            fill++;
          end
        end
        if (fill >= BYTE_W) begin
          if (made < MAX_BYTES) begin
            fresh[made].data = acc[BYTE_W-1:0];
            fresh[made].last = 1'b0;
            made++;
          end
          acc  = acc >> BYTE_W;
          fill = fill - BYTE_W;
        end
      end
      if (made > 0) fresh[made-1].last = 1'b1;
      for (int i = 0; i < made; i++) pending_bytes.insert(pending_bytes.size(), fresh[i]);
      carry_count = CCOUNT_W'(fill);
      carry_bits  = acc[CARRY_W-1:0];
    endfunction

    // compare one output beat with the oldest expected byte
    function bit match_byte(input logic [BYTE_W-1:0] got_data, input logic got_last,
                            output string why);
      packed_byte_t want;
      why = "";
      if (pending_bytes.size() == 0) begin
        $sformat(why, "byte %02h last %0b arrived with nothing expected", got_data, got_last);
        return 1'b0;
      end
      want = pending_bytes[0];
      pending_bytes.delete(0);
      if (got_data !== want.data)
        $sformat(why, "out_byte got %02h want %02h;", got_data, want.data);
      if (got_last !== want.last)
        $sformat(why, "%s last_of_run got %0b want %0b", why, got_last, want.last);
      return why.len() == 0;
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // clock, reset, channels, block
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  ssbp_word_if words_if ();
  ssbp_byte_if bytes_if ();

  self_shrinking_bit_packer uut (
    .clk          (clk),
    .rst          (rst),
    .words        (words_if),
    .packed_bytes (bytes_if)
  );

  shrink_scoreboard sb = new();
  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit send_quiet     = 1'b0;  // sender runs back to back while set
  bit recv_quiet     = 1'b0;  // receiver never stalls while set

  task automatic report_mismatch(input string why);
    mismatch_count++;
    $display("[%0t] packed byte mismatch: %s", $realtime, why);
  endtask

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // -------------------------------------------------------------------------
  // word sender
  // -------------------------------------------------------------------------
  // valid stays high between back-to-back beats; it only drops for a gap
  task automatic send_word(input logic [WORD_W-1:0] word);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      words_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    words_if.valid       <= 1'b1;
    words_if.source_word <= word;
    do @(posedge clk); while (!words_if.ready);
    sb.take_word(word);
  endtask

  // drop valid and hold off until every expected byte has left the block;
  // always waits for a clock edge first so valid never gets two updates a step
  task automatic hold_until_drained();
    words_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // random words, weighted toward ones that keep many bits
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] raw;
    logic [WORD_W-1:0] word;
    int                kind;
    raw  = {$urandom(), $urandom()};
    kind = $urandom_range(0, 99);
    word = raw;
    if (kind < 40) begin
      // every pair keeps its bit: four bytes out per word
      word = raw | 64'hAAAA_AAAA_AAAA_AAAA;
    end else if (kind < 70) begin
      word = raw;
    end else if (kind < 85) begin
      // almost nothing kept: at most one bit, the carry fills slowly
      word = (raw & 64'h5555_5555_5555_5555) | (64'h2 << (2 * $urandom_range(0, 31)));
    end else begin
      // lane by lane mix of the corner bytes and random ones
      for (int lane = 0; lane < MAX_LANES; lane++) begin
        case ($urandom_range(0, 4))
          0:       word[BYTE_W*lane +: BYTE_W] = 8'h00;
          1:       word[BYTE_W*lane +: BYTE_W] = 8'hFF;
          2:       word[BYTE_W*lane +: BYTE_W] = 8'hAA;
          3:       word[BYTE_W*lane +: BYTE_W] = 8'h55;
          default: word[BYTE_W*lane +: BYTE_W] = 8'($urandom());
        endcase
      end
    end
    return word;
  endfunction

  // -------------------------------------------------------------------------
  // byte receiver: one stall draw per beat, with quiet stretches
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    bytes_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 15) == 0) recv_quiet = ~recv_quiet;
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        bytes_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      bytes_if.ready <= 1'b1;
      // ready was high at this edge, so a valid byte is a beat
      do @(posedge clk); while (!bytes_if.valid);
    end
  end

  // -------------------------------------------------------------------------
  // byte checker, sampled at the edge before any update lands
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    string why;
    if (!rst && bytes_if.valid && bytes_if.ready) begin
      if (!sb.match_byte(bytes_if.out_byte, bytes_if.last_of_run, why))
        report_mismatch(why);
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: too long without a beat on either channel ends the run
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (words_if.valid && words_if.ready) || (bytes_if.valid && bytes_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    words_if.valid       <= 1'b0;
    words_if.source_word <= '0;
    rst                  <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corner words first
    send_word(64'h0000_0000_0000_0000);  // nothing kept, no byte
    send_word(64'h5555_5555_5555_5555);  // every upper bit clear, no byte
    send_word(64'hFFFF_FFFF_FFFF_FFFF);  // 32 ones kept, four bytes
    send_word(64'hAAAA_AAAA_AAAA_AAAA);  // 32 zeros kept, four bytes
    send_word(64'hCCCC_CCCC_CCCC_CCCC);  // two kept per lane
    send_word(64'h3333_3333_3333_3333);
    send_word(64'hFFFF_FFFF_0000_0000);  // only the upper lanes keep
    send_word(64'h0000_0000_FFFF_FFFF);  // only the lower lanes keep
    send_word(64'h8000_0000_0000_0000);  // top pair keeps a zero
    // single kept bits fill the carry up to seven, then spill one byte
    repeat (7) send_word(64'h0000_0000_0000_0003);
    // full word on an empty carry: four bytes, nothing left over
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0000_0000_0000_00C0);
    send_word(64'hF0F0_F0F0_F0F0_F0F0);
    send_word(64'h0F0F_0F0F_0F0F_0F0F);
    send_word(64'h9C63_A5E1_7B28_D40F);
    send_word(64'hFFFF_FFFF_FFFF_FFFF);
    hold_until_drained();

    // random words, pausing for a full drain now and then
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 32 == 0) send_quiet = $urandom_range(0, 2) == 0;
      if (n % 64 == 63) hold_until_drained();
      send_word(pick_word());
    end

    // wait for the last bytes, then let the pipeline settle
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
